// ----- design/lcs_pkg.sv -----
// shared types and constants of the linear contrast stretch block
// used by every module of the block; depends on nothing
package lcs_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_SCAN    = 2'd0,
    FUNC_MAP     = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  // configuration register indexes
  localparam logic [1:0] CFG_USE_GIVEN  = 2'd0;
  localparam logic [1:0] CFG_GIVEN_LOW  = 2'd1;
  localparam logic [1:0] CFG_GIVEN_HIGH = 2'd2;

  localparam logic [7:0] FULL_SCALE = 8'hFF;

  // map queue between front and back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  // one map request with its resolved bounds
  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] lo;
    logic [7:0] hi;
  } map_item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- design/linear_contrast_stretch_core.sv -----
// Linear contrast stretch, 8-bit pixels.
// Input channel (in_valid_i/in_ready_o) takes requests: func_i selects scan
// (update running min/max), map (stretch pixel_i) or restart (clear min/max).
// Only map requests produce a result on the output channel
// (out_valid_o/out_ready_i): stretched_o with the bounds low_used_o/high_used_o.
// Config channel (cfg_valid_i/cfg_ready_o) writes use_given_bounds, given_low
// and given_high by cfg_index_i; it is always ready.
// Scan and restart requests are taken one per cycle while the queue is not full.
// A map request whose pixel is clamped to 0 or 255 passes through the queue and
// then the output register, one per cycle while the receiver is ready. Any other
// map request runs the bit-serial divider of the back part: a load, one quotient
// bit per cycle and a write-out; the back pops no new request until then.
// A 4-entry queue sits between front and back; the front keeps accepting
// requests until it fills while the back or the receiver stalls.
// Reset clears min to 255, max to 0, config to disabled with bounds 0..255,
// and empties the queue and output register.
module linear_contrast_stretch_core import lcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [7:0] pixel_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] stretched_o,
  output logic [7:0] low_used_o,
  output logic [7:0] high_used_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic      push, pop;
  map_item_t push_item, head;
  q_status_t q_status;

  // front: accept and classify requests
  lcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .pixel_i     (pixel_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // map request queue
  lcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // back: stretch and deliver
  lcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stretched_o (stretched_o),
    .low_used_o  (low_used_o),
    .high_used_o (high_used_o)
  );

endmodule

// ----- design/lcs_front.sv -----
// front part: accepts items, keeps the running min/max and config registers,
// resolves bounds of map requests and pushes them to the queue; uses lcs_pkg
module lcs_front import lcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [7:0] pixel_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output map_item_t  push_item_o
);

  logic       use_given_q, use_given_d;
  logic [7:0] given_low_q, given_low_d;
  logic [7:0] given_high_q, given_high_d;
  logic [7:0] scan_min_q, scan_min_d;
  logic [7:0] scan_max_q, scan_max_d;
  logic       accept;
  logic       given_ok;

  assign in_ready_o  = !q_status_i.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  // bound selection for map requests
  assign given_ok = use_given_q && (given_high_q >= given_low_q);
  assign push_item_o.pixel = pixel_i;
  assign push_item_o.lo    = given_ok ? given_low_q  : scan_min_q;
  assign push_item_o.hi    = given_ok ? given_high_q : scan_max_q;
  assign push_o = accept && (func_e'(func_i) == FUNC_MAP);

  // configuration writes
  always_comb begin
    use_given_d  = use_given_q;
    given_low_d  = given_low_q;
    given_high_d = given_high_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_USE_GIVEN:  use_given_d  = cfg_data_i[0];
        CFG_GIVEN_LOW:  given_low_d  = cfg_data_i;
        CFG_GIVEN_HIGH: given_high_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // running min/max tracking
  always_comb begin
    scan_min_d = scan_min_q;
    scan_max_d = scan_max_q;
    if (accept) begin
      case (func_e'(func_i))
        FUNC_SCAN: begin
          if (pixel_i < scan_min_q) scan_min_d = pixel_i;
          if (pixel_i > scan_max_q) scan_max_d = pixel_i;
        end
        FUNC_RESTART: begin
          scan_min_d = FULL_SCALE;
          scan_max_d = 8'h00;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_given_q  <= 1'b0;
      given_low_q  <= 8'h00;
      given_high_q <= FULL_SCALE;
      scan_min_q   <= FULL_SCALE;
      scan_max_q   <= 8'h00;
    end else begin
      use_given_q  <= use_given_d;
      given_low_q  <= given_low_d;
      given_high_q <= given_high_d;
      scan_min_q   <= scan_min_d;
      scan_max_q   <= scan_max_d;
    end
  end

endmodule

// ----- design/lcs_queue.sv -----
// short queue of map requests between front and back parts
// uses map_item_t and the queue depth from lcs_pkg
module lcs_queue import lcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  map_item_t push_item_i,
  input  logic      pop_i,
  output map_item_t head_o,
  output q_status_t status_o
);

  map_item_t          mem_q [QDepth];
  logic [QAw-1:0]     wptr_q, rptr_q;
  logic [QCw-1:0]     count_q, count_d;

  assign status_o.full  = (count_q == QCw'(QDepth));
  assign status_o.empty = (count_q == '0);
  assign head_o = mem_q[rptr_q];

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_item_i;
  end

endmodule

// ----- design/lcs_back.sv -----
// back part: pops map requests, clamps or runs a bit-serial divide,
// and holds the result in the output register; uses lcs_pkg
module lcs_back import lcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  map_item_t  head_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] stretched_o,
  output logic [7:0] low_used_o,
  output logic [7:0] high_used_o
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_DIV  = 3'b010,
    BK_DONE = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  quo_q, quo_d;
  logic [7:0]  div_q, div_d;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  hi_q, hi_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  stretched_q, low_q, high_q;

  logic        out_free;
  logic        ge_hi, le_lo, trivial;
  logic [7:0]  diff, span;
  logic [15:0] num;
  logic [8:0]  trial, trial_sub;
  logic        qbit;
  logic        wr_out;
  logic [7:0]  wr_stretched, wr_low, wr_high;

  assign out_free = !out_valid_q || out_ready_i;

  // clamp tests on the head request
  assign ge_hi   = head_i.pixel >= head_i.hi;
  assign le_lo   = head_i.pixel <= head_i.lo;
  assign trivial = ge_hi || le_lo;

  // numerator (p - lo) * 255 and divisor hi - lo
  assign diff = head_i.pixel - head_i.lo;
  assign span = head_i.hi - head_i.lo;
  assign num  = {diff, 8'h00} - {8'h00, diff};

  // one restoring divide step
  assign trial     = {rem_q, quo_q[7]};
  assign trial_sub = trial - {1'b0, div_q};
  assign qbit      = (trial >= {1'b0, div_q});

  assign pop_o = (state_q == BK_IDLE) && !q_status_i.empty && (!trivial || out_free);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_o && !trivial) begin
          rem_d   = num[15:8];
          quo_d   = num[7:0];
          div_d   = span;
          lo_d    = head_i.lo;
          hi_d    = head_i.hi;
          cnt_d   = '0;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_d = qbit ? trial_sub[7:0] : trial[7:0];
        quo_d = {quo_q[6:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd7) state_d = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // output register load
  always_comb begin
    wr_out       = 1'b0;
    wr_stretched = quo_q;
    wr_low       = lo_q;
    wr_high      = hi_q;
    if (pop_o && trivial) begin
      wr_out       = 1'b1;
      wr_stretched = ge_hi ? FULL_SCALE : 8'h00;
      wr_low       = head_i.lo;
      wr_high      = head_i.hi;
    end else if ((state_q == BK_DONE) && out_free) begin
      wr_out = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (wr_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    if (wr_out) begin
      stretched_q <= wr_stretched;
      low_q       <= wr_low;
      high_q      <= wr_high;
    end
  end

  assign out_valid_o = out_valid_q;
  assign stretched_o = stretched_q;
  assign low_used_o  = low_q;
  assign high_used_o = high_q;

`ifndef SYNTHESIS
  // partial remainder stays below the divisor during the divide
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (rem_q < div_q))
    else $error("divide remainder not below divisor");

  // never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !q_status_i.empty)
    else $error("pop from empty queue");

  // a finished divide lands in the output register
  a_done_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_DONE) && out_free) |=> (out_valid_o && (state_q == BK_IDLE)))
    else $error("finished divide not delivered");
`endif

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for linear_contrast_stretch_core
// directed table then random scan/map scenes under several bound settings;
// depends on lcs_pkg and the core rtl
`timescale 1ns / 100ps

module tb_top;
  import lcs_pkg::*;

  localparam int SETTLE      = 16;   // cycles past the last result before a config write
  localparam int PHASE_ITEMS = 76;
  localparam int PHASES      = 8;

  // codes that the package leaves unnamed
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  typedef struct packed {
    logic [7:0] stretched;
    logic [7:0] low_used;
    logic [7:0] high_used;
  } stretch_res_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // one line of the directed script: a request or a register write
  typedef struct packed {
    row_kind_e    kind;
    logic [1:0]   code;
    logic [7:0]   data;
    logic         typed;
    stretch_res_t res;
  } row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [1:0] func_i      = FUNC_SCAN;
  logic [7:0] pixel_i     = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] stretched_o;
  logic [7:0] low_used_o;
  logic [7:0] high_used_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = CFG_USE_GIVEN;
  logic [7:0] cfg_data_i  = 8'd0;

  // predictor state
  logic [7:0]   seen_min = 8'd255;
  logic [7:0]   seen_max = 8'd0;
  logic         cfg_use  = 1'b0;
  logic [7:0]   cfg_low  = 8'd0;
  logic [7:0]   cfg_high = 8'd255;
  stretch_res_t awaited_maps[$];
  int unsigned  fault_count = 0;
  bit           steady = 1'b0;
  row_t         script[$];

  linear_contrast_stretch_core uut (.*);

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #500000;
    $display("tb_top: done, errors");
    $finish;
  end

  // bounds applied to a map request under the current settings
  function automatic void pick_bounds(output logic [7:0] lo, output logic [7:0] hi);
    if (cfg_use && cfg_high >= cfg_low) begin
      lo = cfg_low;
      hi = cfg_high;
    end else begin
      lo = seen_min;
      hi = seen_max;
    end
  endfunction

  // clamp tests first, then exact integer scaling
  function automatic logic [7:0] stretch_value(input logic [7:0] p, input logic [7:0] lo,
                                               input logic [7:0] hi);
    int num;
    int den;
    if (p >= hi) return FULL_SCALE;
    if (p <= lo) return 8'd0;
    num = (int'(p) - int'(lo)) * 255;
    den = int'(hi) - int'(lo);
    return 8'(num / den);
  endfunction

  // value one step around v, kept in range
  function automatic logic [7:0] near(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(2)) - 1;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  // update scan state and queue the result of an accepted request
  task automatic apply_request(input logic [1:0] f, input logic [7:0] p, input bit typed,
                               input stretch_res_t given);
    stretch_res_t res;
    logic [7:0]   lo;
    logic [7:0]   hi;
    case (f)
      FUNC_SCAN: begin
        if (p < seen_min) seen_min = p;
        if (p > seen_max) seen_max = p;
      end
      FUNC_RESTART: begin
        seen_min = 8'd255;
        seen_max = 8'd0;
      end
      FUNC_MAP: begin
        pick_bounds(lo, hi);
        res.stretched = stretch_value(p, lo, hi);
        res.low_used  = lo;
        res.high_used = hi;
        awaited_maps.push_back(typed ? given : res);
      end
      default: ;
    endcase
  endtask

  // drive one request, with random idle cycles ahead of it unless steady
  task automatic send_request(input logic [1:0] f, input logic [7:0] p, input bit typed,
                              input stretch_res_t given);
    if (!steady) begin
      while ($urandom_range(99) < 25) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    pixel_i    <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_request(f, p, typed, given);
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_maps.size() != 0) @(posedge clk_i);
  endtask

  // register write, only once the block has gone quiet
  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_USE_GIVEN:  cfg_use  = val[0];
      CFG_GIVEN_LOW:  cfg_low  = val;
      CFG_GIVEN_HIGH: cfg_high = val;
      default: ;
    endcase
  endtask

  // restart most times, a burst of scans over a window, then maps at random, near or between the bounds
  task automatic run_scene(inout int unsigned sent);
    int unsigned a;
    int unsigned b;
    int unsigned nscan;
    int unsigned nmap;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  px;
    if ($urandom_range(99) < 70) begin
      send_request(FUNC_RESTART, 8'($urandom), 1'b0, '0);
      sent++;
    end
    a = $urandom_range(255);
    b = $urandom_range(255, a);
    if ($urandom_range(2) == 0 && a <= 250) b = a + $urandom_range(4);
    nscan = $urandom_range(8);
    repeat (nscan) begin
      if ($urandom_range(99) < 4) send_request(FUNC_UNUSED, 8'($urandom), 1'b0, '0);
      send_request(FUNC_SCAN, 8'($urandom_range(b, a)), 1'b0, '0);
      sent++;
    end
    nmap = $urandom_range(10, 1);
    repeat (nmap) begin
      if ($urandom_range(99) < 4) send_request(FUNC_UNUSED, 8'($urandom), 1'b0, '0);
      pick_bounds(lo, hi);
      case ($urandom_range(3))
        0:       px = 8'($urandom);
        1:       px = near(lo);
        2:       px = near(hi);
        default: px = (lo < hi) ? 8'($urandom_range(hi, lo)) : 8'($urandom);
      endcase
      send_request(FUNC_MAP, px, 1'b0, '0);
      sent++;
    end
    if ($urandom_range(7) == 0) drain_results();
  endtask

  // receiver with random stalls outside the steady phase
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 25);
  end

  // result checker
  always @(posedge clk_i) begin : result_check
    stretch_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_maps.size() == 0) begin
        $error("unexpected result: stretched %0d low_used %0d high_used %0d",
               stretched_o, low_used_o, high_used_o);
        fault_count++;
      end else begin
        want = awaited_maps.pop_front();
        if (stretched_o !== want.stretched) begin
          $error("stretched: expected %0d, actual %0d", want.stretched, stretched_o);
          fault_count++;
        end
        if (low_used_o !== want.low_used) begin
          $error("low_used: expected %0d, actual %0d", want.low_used, low_used_o);
          fault_count++;
        end
        if (high_used_o !== want.high_used) begin
          $error("high_used: expected %0d, actual %0d", want.high_used, high_used_o);
          fault_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned sent;
    int unsigned lo_set;
    int unsigned hi_set;
    logic        use_set;

    // directed script: typed results where they are obvious, predictor elsewhere
    script = '{
      '{ROW_REQ, FUNC_MAP,       8'd0,   1'b1, '{8'd255, 8'd255, 8'd0}},
      '{ROW_REQ, FUNC_MAP,       8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{ROW_REQ, FUNC_SCAN,      8'd100, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd100, 1'b1, '{8'd255, 8'd100, 8'd100}},
      '{ROW_REQ, FUNC_MAP,       8'd99,  1'b1, '{8'd0,   8'd100, 8'd100}},
      '{ROW_REQ, FUNC_SCAN,      8'd0,   1'b0, '0},
      '{ROW_REQ, FUNC_SCAN,      8'd255, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd128, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd1,   1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd254, 1'b0, '0},
      '{ROW_REQ, FUNC_UNUSED,    8'd0,   1'b0, '0},
      '{ROW_REQ, FUNC_UNUSED,    8'd255, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd0,   1'b1, '{8'd0,   8'd0,   8'd255}},
      '{ROW_REQ, FUNC_RESTART,   8'd170, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd50,  1'b1, '{8'd255, 8'd255, 8'd0}},
      '{ROW_CFG, CFG_USE_GIVEN,  8'd1,   1'b0, '0},
      '{ROW_CFG, CFG_GIVEN_LOW,  8'd10,  1'b0, '0},
      '{ROW_CFG, CFG_GIVEN_HIGH, 8'd200, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd10,  1'b1, '{8'd0,   8'd10,  8'd200}},
      '{ROW_REQ, FUNC_MAP,       8'd200, 1'b1, '{8'd255, 8'd10,  8'd200}},
      '{ROW_REQ, FUNC_MAP,       8'd105, 1'b0, '0},
      '{ROW_CFG, CFG_UNUSED,     8'd255, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd9,   1'b1, '{8'd0,   8'd10,  8'd200}},
      '{ROW_CFG, CFG_GIVEN_LOW,  8'd201, 1'b0, '0},
      '{ROW_REQ, FUNC_SCAN,      8'd85,  1'b0, '0},
      '{ROW_REQ, FUNC_SCAN,      8'd170, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd128, 1'b0, '0},
      '{ROW_CFG, CFG_GIVEN_LOW,  8'd200, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd200, 1'b1, '{8'd255, 8'd200, 8'd200}},
      '{ROW_REQ, FUNC_MAP,       8'd199, 1'b1, '{8'd0,   8'd200, 8'd200}},
      '{ROW_CFG, CFG_GIVEN_LOW,  8'd0,   1'b0, '0},
      '{ROW_CFG, CFG_GIVEN_HIGH, 8'd255, 1'b0, '0},
      '{ROW_REQ, FUNC_MAP,       8'd0,   1'b1, '{8'd0,   8'd0,   8'd255}},
      '{ROW_REQ, FUNC_MAP,       8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}}
    };

    // reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) write_register(script[i].code, script[i].data);
      else send_request(script[i].code, script[i].data, script[i].typed, script[i].res);
    end

    // random part, one bound setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      use_set = 1'b1;
      case (ph)
        0: begin
          use_set = 1'b0;
          lo_set  = $urandom_range(255);
          hi_set  = $urandom_range(255);
        end
        1: begin
          lo_set = 0;
          hi_set = 255;
        end
        2: begin
          lo_set = $urandom_range(200);
          hi_set = $urandom_range(255, lo_set + 2);
        end
        3: begin
          hi_set = $urandom_range(254);
          lo_set = $urandom_range(255, hi_set + 1);
        end
        4: begin
          lo_set = $urandom_range(255);
          hi_set = lo_set;
        end
        5: begin
          lo_set = 0;
          hi_set = 0;
        end
        6: begin
          use_set = 1'b0;
          lo_set  = 255;
          hi_set  = 0;
        end
        default: begin
          lo_set = $urandom_range(255);
          hi_set = $urandom_range(255);
        end
      endcase
      write_register(CFG_USE_GIVEN, {7'd0, use_set});
      write_register(CFG_GIVEN_LOW, 8'(lo_set));
      write_register(CFG_GIVEN_HIGH, 8'(hi_set));
      // in phase 1, one long stretch with neither side idling
      steady <= (ph == 1);
      sent = 0;
      while (sent < PHASE_ITEMS) run_scene(sent);
    end

    // wind down
    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (fault_count == 0 && awaited_maps.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/lcs_pkg.sv
design/lcs_front.sv
design/lcs_queue.sv
design/lcs_back.sv
design/linear_contrast_stretch_core.sv
verif/tb_top.sv
